// ----- hw/rtl/lzbu_pkg.sv -----
// ----------------------------------------------------------------------------
// lzbu_pkg
// Shared types and constants for the bitstream unpacker: decode phases,
// controller states, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lzbu_pkg;

	localparam int OUT_LANES       = 8;
	localparam int LANE_IW         = $clog2(OUT_LANES);
	localparam int BCNT_W          = 4;
	localparam int SIZE_W          = 24;
	localparam int LEN_W           = 9;
	localparam int OHI_W           = 4;
	localparam int RUN_W           = 7;
	localparam int DEF_WINDOW_SIZE = 4096;
	localparam int DEF_COUNT_WIDTH = 24;

	// configuration register indexes
	localparam logic REG_PACKED_SIZE   = 1'b0;
	localparam logic REG_UNPACKED_SIZE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_IN_OVR     = 2'd1;
	localparam logic [1:0] ST_OUT_OVR    = 2'd2;
	localparam logic [1:0] ST_BAD_OFFSET = 2'd3;

	typedef enum logic [4:0] {
		PH_TOSS1, PH_TOSS2, PH_CMD, PH_LIT, PH_A, PH_B, PH_C, PH_D,
		PH_R1, PH_R2, PH_R3, PH_R4, PH_RUN, PH_E, PH_F, PH_LEN8,
		PH_ENDBIT, PH_OFF0, PH_O1, PH_O2, PH_O3, PH_O4, PH_O5, PH_O6,
		PH_OFFLOW
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DRAIN, S_COPY_RD, S_COPY_WR, S_PUSH, S_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic step;
		logic drain;
		logic rd;
		logic wr;
		logic push;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic drain_busy;
		logic copy_pending;
		logic copy_last;
		logic lane_near_full;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/lzbu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzbu_ctrl
// Sequencer: takes an item, drains control bits, copies match bytes one at a
// time through the history and hands finished result beats to the output.
// ----------------------------------------------------------------------------
module lzbu_ctrl
	import lzbu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.step = 1'b1;
					state_d  = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.drain_busy) begin
					cmd.drain = 1'b1;
				end else if (sts.copy_pending) begin
					state_d = S_COPY_RD;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_COPY_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.wr = 1'b1;
				if (sts.copy_last) begin
					state_d = S_FLUSH;
				end else if (sts.lane_near_full) begin
					state_d = S_PUSH;
				end else begin
					state_d = S_COPY_RD;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_COPY_RD;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/lzbu_datapath.sv -----
// ----------------------------------------------------------------------------
// lzbu_datapath
// Decode state, bit buffer, counters, history memory, lane assembly and the
// output register.
// ----------------------------------------------------------------------------
module lzbu_datapath
	import lzbu_pkg::*;
#(
	parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic [7:0]                    packed_byte,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [OUT_LANES-1:0][7:0]     out_lanes,
	output logic [BCNT_W-1:0]             out_count,
	output logic                          out_last,
	output logic                          out_done,
	output logic [1:0]                    out_status
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int EW = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;
	localparam int OW = 13;
	localparam int SW = (AW > OW) ? AW : OW;

	typedef struct packed {
		phase_t            phase;
		logic [LEN_W-1:0]  plen;
		logic [OHI_W-1:0]  ohigh;
		logic [RUN_W-1:0]  rr;
		logic              stop;
	} dec_t;

	// one control bit through the phase machine
	function automatic dec_t take_bit(phase_t ph, logic b, logic [LEN_W-1:0] plen,
		logic [OHI_W-1:0] oh, logic [RUN_W-1:0] rr);
		dec_t             r;
		logic [OHI_W-1:0] h;
		logic [LEN_W-1:0] pm1;
		logic [4:0]       h3;
		r.phase = ph;
		r.plen  = plen;
		r.ohigh = oh;
		r.rr    = rr;
		r.stop  = 1'b0;
		h       = {oh[2:0], b};
		pm1     = plen - LEN_W'(1);
		h3      = {1'b0, h} + 5'd3;
		case (ph)
			PH_TOSS1: r.phase = PH_TOSS2;
			PH_TOSS2: r.phase = PH_CMD;
			PH_CMD:   r.phase = b ? PH_A : PH_LIT;
			PH_A:     r.phase = b ? PH_E : PH_B;
			PH_B: begin
				r.plen  = LEN_W'(4) + LEN_W'(b);
				r.phase = PH_C;
			end
			PH_C:     r.phase = b ? PH_D : PH_OFF0;
			PH_D: begin
				r.plen = {pm1[LEN_W-2:0], b};
				if ({pm1[LEN_W-2:0], b} == LEN_W'(9)) begin
					r.ohigh = '0;
					r.phase = PH_R1;
				end else begin
					r.phase = PH_OFF0;
				end
			end
			PH_R1: begin
				r.ohigh = h;
				r.phase = PH_R2;
			end
			PH_R2: begin
				r.ohigh = h;
				r.phase = PH_R3;
			end
			PH_R3: begin
				r.ohigh = h;
				r.phase = PH_R4;
			end
			PH_R4: begin
				r.ohigh = h;
				r.rr    = {h3, 2'b00};
				r.phase = PH_RUN;
			end
			PH_E: begin
				if (b) begin
					r.phase = PH_F;
				end else begin
					r.plen  = LEN_W'(2);
					r.ohigh = '0;
					r.phase = PH_OFFLOW;
				end
			end
			PH_F: begin
				if (b) begin
					r.phase = PH_LEN8;
				end else begin
					r.plen  = LEN_W'(3);
					r.phase = PH_OFF0;
				end
			end
			PH_ENDBIT: begin
				if (b) begin
					r.phase = PH_CMD;
				end else begin
					r.stop = 1'b1;
				end
			end
			PH_OFF0: begin
				if (b) begin
					r.phase = PH_O1;
				end else begin
					r.ohigh = '0;
					r.phase = PH_OFFLOW;
				end
			end
			PH_O1: begin
				r.ohigh = OHI_W'(b);
				r.phase = PH_O2;
			end
			PH_O2: begin
				if (b) begin
					r.phase = PH_O3;
				end else begin
					r.phase = (oh == '0) ? PH_O5 : PH_OFFLOW;
				end
			end
			PH_O3: begin
				r.ohigh = h + OHI_W'(4);
				r.phase = PH_O4;
			end
			PH_O4:    r.phase = b ? PH_OFFLOW : PH_O6;
			PH_O5: begin
				r.ohigh = OHI_W'(2) + OHI_W'(b);
				r.phase = PH_OFFLOW;
			end
			PH_O6: begin
				r.ohigh = h;
				r.phase = PH_OFFLOW;
			end
			default:  r.phase = PH_CMD;
		endcase
		return r;
	endfunction

	// configuration
	logic [SIZE_W-1:0] psize_q, usize_q;

	// decode state
	phase_t               phase_q, phase_d;
	logic [7:0]           bitbuf_q, bitbuf_d;
	logic [LEN_W-1:0]     plen_q, plen_d;
	logic [OHI_W-1:0]     ohigh_q, ohigh_d;
	logic [RUN_W-1:0]     rr_q, rr_d;
	logic [COUNT_WIDTH-1:0] bw_q, bw_d, br_q, br_d;
	logic                 fin_q, fin_d;
	logic [1:0]           fault_q, fault_d;
	logic [LEN_W-1:0]     cp_rem_q, cp_rem_d;
	logic [AW-1:0]        src_q, src_d;

	// history and lanes
	logic [7:0]           hist [WINDOW_SIZE];
	logic [AW-1:0]        wr_ptr_q;
	logic [7:0]           rd_data_q;
	logic                 hist_we;
	logic [7:0]           hist_wdata;
	logic [7:0]           lane_q [OUT_LANES];
	logic [BCNT_W-1:0]    lane_cnt_q;

	// output register
	logic                      out_valid_q, out_last_q, out_done_q;
	logic [OUT_LANES-1:0][7:0] out_lanes_q;
	logic [BCNT_W-1:0]         out_count_q;
	logic [1:0]                out_status_q;

	logic [EW-1:0]    bw_x, br_x, ps_x, us_x, avail;
	logic             bw_lt, br_ge, lim, is_data, short_copy, off_gt, we_step;
	logic [LEN_W-1:0] ncopy;
	logic [OW-1:0]    ofs;
	logic [SW-1:0]    src_diff;
	logic [RUN_W-1:0] rr_dec;
	dec_t             sdec, ddec;

	assign bw_x       = EW'(bw_q);
	assign br_x       = EW'(br_q);
	assign ps_x       = EW'(psize_q);
	assign us_x       = EW'(usize_q);
	assign bw_lt      = bw_x < us_x;
	assign br_ge      = br_x >= ps_x;
	assign lim        = !bw_lt || br_ge;
	assign is_data    = (phase_q == PH_LIT) || (phase_q == PH_RUN) ||
	                    (phase_q == PH_LEN8) || (phase_q == PH_OFFLOW);
	assign avail      = us_x - bw_x;
	assign short_copy = !bw_lt || (EW'(plen_q) > avail);
	assign ncopy      = !bw_lt ? '0 : (short_copy ? avail[LEN_W-1:0] : plen_q);
	assign ofs        = {1'b0, ohigh_q, packed_byte} + OW'(1);
	assign off_gt     = EW'(ofs) > bw_x;
	assign src_diff   = SW'(wr_ptr_q) - SW'(ofs);
	assign rr_dec     = (rr_q != '0) ? rr_q - RUN_W'(1) : '0;
	assign sdec       = take_bit(phase_q, packed_byte[7], plen_q, ohigh_q, rr_q);
	assign ddec       = take_bit(phase_q, bitbuf_q[7], plen_q, ohigh_q, rr_q);

	// next decode state
	always_comb begin
		phase_d  = phase_q;
		bitbuf_d = bitbuf_q;
		plen_d   = plen_q;
		ohigh_d  = ohigh_q;
		rr_d     = rr_q;
		bw_d     = bw_q;
		br_d     = br_q;
		fin_d    = fin_q;
		fault_d  = fault_q;
		cp_rem_d = cp_rem_q;
		src_d    = src_q;
		we_step  = 1'b0;
		if (cmd.step && !fin_q) begin
			if (br_ge) begin
				fin_d   = 1'b1;
				fault_d = ST_IN_OVR;
			end else begin
				br_d = br_q + COUNT_WIDTH'(1);
				if (is_data) begin
					case (phase_q)
						PH_LIT: begin
							phase_d = PH_CMD;
							if (bw_lt) begin
								we_step = 1'b1;
								bw_d    = bw_q + COUNT_WIDTH'(1);
							end else begin
								fin_d   = 1'b1;
								fault_d = ST_OUT_OVR;
							end
						end
						PH_RUN: begin
							if (bw_lt) begin
								we_step = 1'b1;
								bw_d    = bw_q + COUNT_WIDTH'(1);
								rr_d    = rr_dec;
								if (rr_dec == '0) begin
									phase_d = PH_CMD;
								end
							end else begin
								fin_d   = 1'b1;
								fault_d = ST_OUT_OVR;
							end
						end
						PH_LEN8: begin
							if (packed_byte == 8'd0) begin
								phase_d = PH_ENDBIT;
							end else begin
								plen_d  = {1'b0, packed_byte} + LEN_W'(8);
								phase_d = PH_OFF0;
							end
						end
						default: begin
							phase_d = PH_CMD;
							if (off_gt) begin
								fin_d   = 1'b1;
								fault_d = ST_BAD_OFFSET;
							end else begin
								cp_rem_d = ncopy;
								bw_d     = bw_q + COUNT_WIDTH'(ncopy);
								src_d    = src_diff[AW-1:0];
								if (short_copy) begin
									fin_d   = 1'b1;
									fault_d = ST_OUT_OVR;
								end
							end
						end
					endcase
				end else begin
					bitbuf_d = {packed_byte[6:0], 1'b1};
					phase_d  = sdec.phase;
					plen_d   = sdec.plen;
					ohigh_d  = sdec.ohigh;
					rr_d     = sdec.rr;
					if (sdec.stop) begin
						fin_d   = 1'b1;
						fault_d = ST_OK;
					end
				end
			end
		end else if (cmd.drain) begin
			if (phase_q == PH_CMD && lim) begin
				fin_d   = 1'b1;
				fault_d = ST_OK;
			end else begin
				bitbuf_d = {bitbuf_q[6:0], 1'b0};
				phase_d  = ddec.phase;
				plen_d   = ddec.plen;
				ohigh_d  = ddec.ohigh;
				rr_d     = ddec.rr;
				if (ddec.stop) begin
					fin_d   = 1'b1;
					fault_d = ST_OK;
				end
			end
		end
		// advance the copy pointers
		if (cmd.wr) begin
			cp_rem_d = cp_rem_q - LEN_W'(1);
			src_d    = src_q + AW'(1);
		end
	end

	// decode and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q  <= '0;
			usize_q  <= '0;
			phase_q  <= PH_TOSS1;
			bitbuf_q <= '0;
			plen_q   <= '0;
			ohigh_q  <= '0;
			rr_q     <= '0;
			bw_q     <= '0;
			br_q     <= '0;
			fin_q    <= 1'b0;
			fault_q  <= ST_OK;
			cp_rem_q <= '0;
			src_q    <= '0;
		end else begin
			if (cfg_valid && cfg_index == REG_PACKED_SIZE) begin
				psize_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_UNPACKED_SIZE) begin
				usize_q <= cfg_data;
			end
			phase_q  <= phase_d;
			bitbuf_q <= bitbuf_d;
			plen_q   <= plen_d;
			ohigh_q  <= ohigh_d;
			rr_q     <= rr_d;
			bw_q     <= bw_d;
			br_q     <= br_d;
			fin_q    <= fin_d;
			fault_q  <= fault_d;
			cp_rem_q <= cp_rem_d;
			src_q    <= src_d;
		end
	end

	assign hist_we    = we_step || cmd.wr;
	assign hist_wdata = cmd.wr ? rd_data_q : packed_byte;

	// history memory
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist[wr_ptr_q] <= hist_wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= hist[src_q];
		end
	end

	// append written bytes to the lane buffer
	always_ff @(posedge clk) begin
		if (hist_we) begin
			lane_q[lane_cnt_q[LANE_IW-1:0]] <= hist_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			lane_cnt_q <= '0;
		end else begin
			if (hist_we) begin
				wr_ptr_q   <= wr_ptr_q + AW'(1);
				lane_cnt_q <= lane_cnt_q + BCNT_W'(1);
			end else if (cmd.push || cmd.flush) begin
				lane_cnt_q <= '0;
			end
		end
	end

	// output register: load a beat, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.flush) begin
			for (int j = 0; j < OUT_LANES; j++) begin
				out_lanes_q[j] <= (BCNT_W'(j) < lane_cnt_q) ? lane_q[j] : 8'd0;
			end
			out_count_q  <= lane_cnt_q;
			out_last_q   <= cmd.flush;
			out_done_q   <= fin_q;
			out_status_q <= fault_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_lanes  = out_lanes_q;
	assign out_count  = out_count_q;
	assign out_last   = out_last_q;
	assign out_done   = out_done_q;
	assign out_status = out_status_q;

	assign sts.drain_busy     = !fin_q && ((phase_q == PH_CMD && lim) ||
	                            (!is_data && bitbuf_q[6:0] != 7'd0));
	assign sts.copy_pending   = cp_rem_q != '0;
	assign sts.copy_last      = cp_rem_q == LEN_W'(1);
	assign sts.lane_near_full = lane_cnt_q == BCNT_W'(OUT_LANES - 1);
	assign sts.out_free       = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lane_cnt_q <= BCNT_W'(OUT_LANES))
		else $error("lane buffer overfilled");
	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> cp_rem_q != '0)
		else $error("copy beyond match length");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> out_valid_q && out_last_q)
		else $error("final beat not marked last");
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag cleared");
`endif

endmodule

// ----- hw/rtl/lz_bitstream_unpacker.sv -----
// ----------------------------------------------------------------------------
// lz_bitstream_unpacker
// Streaming RNC method 2 decoder: packed bytes in, beats of up to eight
// decoded bytes out, with a history window for match copies.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, packed_byte            to block
//   out      out_valid/out_ready, out_byte_0..7,       from block
//            byte_count, last_of_run, stream_done, status
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  to block
//
// An item enters, control bits are drained from the bit buffer (up to 7),
// match bytes are copied one at a time through the single history port
// (read, then write), and result beats are handed out; a new item is taken
// only once the last one is flushed. A match copies up to 263 bytes.
// Reset clears the decode state and counters; history is not cleared.
// A stalled output holds the copy; config writes are always taken.
// ----------------------------------------------------------------------------
module lz_bitstream_unpacker
	import lzbu_pkg::*;
#(
	parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        packed_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte_0,
	output logic [7:0]        out_byte_1,
	output logic [7:0]        out_byte_2,
	output logic [7:0]        out_byte_3,
	output logic [7:0]        out_byte_4,
	output logic [7:0]        out_byte_5,
	output logic [7:0]        out_byte_6,
	output logic [7:0]        out_byte_7,
	output logic [BCNT_W-1:0] byte_count,
	output logic              last_of_run,
	output logic              stream_done,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	cmd_t                      cmd;
	sts_t                      sts;
	logic [OUT_LANES-1:0][7:0] lanes;

	lzbu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzbu_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.packed_byte (packed_byte),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_lanes   (lanes),
		.out_count   (byte_count),
		.out_last    (last_of_run),
		.out_done    (stream_done),
		.out_status  (status)
	);

	assign cfg_ready  = 1'b1;
	assign out_byte_0 = lanes[0];
	assign out_byte_1 = lanes[1];
	assign out_byte_2 = lanes[2];
	assign out_byte_3 = lanes[3];
	assign out_byte_4 = lanes[4];
	assign out_byte_5 = lanes[5];
	assign out_byte_6 = lanes[6];
	assign out_byte_7 = lanes[7];

endmodule
